// ----- hdl/fcr_pkg.sv -----
// ----------------------------------------------------------------------------
// fcr_pkg
// Shared types and constants for the frame chunk reassembly checker.
// ----------------------------------------------------------------------------
package fcr_pkg;

    localparam int HEADER_BYTES    = 48;
    localparam int MAX_CHUNK_BYTES = 8192;
    localparam int MAX_FRAME_BYTES = 524288;
    localparam int MAX_CHUNKS      = 64;

    // widths of tracked quantities (sized to hold the maxima above)
    localparam int FRAME_BYTES_W = 20;
    localparam int CHUNK_CNT_W   = 7;
    localparam int WR_OFFSET_W   = 19;
    localparam int WR_LENGTH_W   = 14;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_STREAM_INFO_VALID  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_STREAM_ID = 1'd1;

    typedef enum logic [1:0] {
        VERDICT_ACCEPTED = 2'd0,
        VERDICT_MALFORMED = 2'd1,
        VERDICT_STRAY_START = 2'd2,
        VERDICT_MISMATCH = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [15:0] packet_size;
        logic [15:0] chunk_data_size;
        logic [31:0] stream_id;
        logic [31:0] total_frame_size;
        logic [15:0] chunk_count;
        logic [15:0] chunk_index;
        logic [31:0] chunk_offset;
        logic [63:0] frame_id;
        logic [63:0] time_stamp;
        logic [7:0]  kind_of_frame;
    } chunk_t;

    typedef struct packed {
        verdict_t                 verdict;
        logic                     prior_frame_dropped;
        logic [WR_OFFSET_W-1:0]   write_offset;
        logic [WR_LENGTH_W-1:0]   write_length;
        logic                     frame_complete;
        logic [63:0]              done_frame_id;
        logic [63:0]              done_time_stamp;
        logic [7:0]               done_frame_kind;
        logic [FRAME_BYTES_W-1:0] done_frame_bytes;
        logic [CHUNK_CNT_W-1:0]   done_chunk_total;
    } result_t;

    // classified chunk handed from front to back; sizes are only
    // meaningful when malformed is low
    typedef struct packed {
        logic                     malformed;
        logic [63:0]              frame_id;
        logic [63:0]              time_stamp;
        logic [7:0]               kind;
        logic [FRAME_BYTES_W-1:0] frame_bytes;
        logic [CHUNK_CNT_W-1:0]   count;
        logic [CHUNK_CNT_W-1:0]   index;
        logic [WR_OFFSET_W-1:0]   offset;
        logic [WR_LENGTH_W-1:0]   length;
    } cls_t;

endpackage

// ----- hdl/fcr_front.sv -----
// ----------------------------------------------------------------------------
// fcr_front
// Holds the configuration registers and runs the stateless header checks,
// registering one classified chunk per cycle unless the command queue is full.
// ----------------------------------------------------------------------------
module fcr_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [fcr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fcr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               push,
    output logic                               full,
    input  fcr_pkg::chunk_t                    chunk,
    output logic                               cls_valid,
    input  logic                               cls_full,
    output fcr_pkg::cls_t                      cls
);

    logic            stream_info_valid_reg;
    logic [31:0]     expected_stream_id_reg;
    logic            stage_valid_reg;
    fcr_pkg::cls_t   stage_reg;
    fcr_pkg::cls_t   cls_next;
    logic            accept;
    logic            bad;
    logic [47:0]     idx_offset;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_info_valid_reg  <= 1'b0;
            expected_stream_id_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fcr_pkg::REG_STREAM_INFO_VALID:  stream_info_valid_reg  <= cfg_data[0];
                fcr_pkg::REG_EXPECTED_STREAM_ID: expected_stream_id_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        idx_offset = 48'(chunk.chunk_index) * 48'(fcr_pkg::MAX_CHUNK_BYTES);
        bad = 1'b0;
        if ({1'b0, chunk.packet_size} !=
            17'(fcr_pkg::HEADER_BYTES) + {1'b0, chunk.chunk_data_size})
            bad = 1'b1;
        if (chunk.chunk_data_size == '0 ||
            {1'b0, chunk.chunk_data_size} > 17'(fcr_pkg::MAX_CHUNK_BYTES))
            bad = 1'b1;
        if (stream_info_valid_reg && chunk.stream_id != expected_stream_id_reg)
            bad = 1'b1;
        if (chunk.total_frame_size == '0 ||
            {1'b0, chunk.total_frame_size} > 33'(fcr_pkg::MAX_FRAME_BYTES))
            bad = 1'b1;
        if (chunk.chunk_count == '0 ||
            {1'b0, chunk.chunk_count} > 17'(fcr_pkg::MAX_CHUNKS) ||
            chunk.chunk_index >= chunk.chunk_count)
            bad = 1'b1;
        if ({1'b0, chunk.chunk_offset} + 33'(chunk.chunk_data_size) >
            {1'b0, chunk.total_frame_size})
            bad = 1'b1;
        if (48'(chunk.chunk_offset) != idx_offset)
            bad = 1'b1;

        cls_next.malformed   = bad;
        cls_next.frame_id    = chunk.frame_id;
        cls_next.time_stamp  = chunk.time_stamp;
        cls_next.kind        = chunk.kind_of_frame;
        cls_next.frame_bytes = chunk.total_frame_size[fcr_pkg::FRAME_BYTES_W-1:0];
        cls_next.count       = chunk.chunk_count[fcr_pkg::CHUNK_CNT_W-1:0];
        cls_next.index       = chunk.chunk_index[fcr_pkg::CHUNK_CNT_W-1:0];
        cls_next.offset      = chunk.chunk_offset[fcr_pkg::WR_OFFSET_W-1:0];
        cls_next.length      = chunk.chunk_data_size[fcr_pkg::WR_LENGTH_W-1:0];
    end

    assign full      = stage_valid_reg & cls_full;
    assign accept    = push & ~full;
    assign cls_valid = stage_valid_reg;
    assign cls       = stage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (accept)
            stage_valid_reg <= 1'b1;
        else if (!cls_full)
            stage_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_reg <= cls_next;
    end

endmodule

// ----- hdl/fcr_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// fcr_cmd_queue
// Two-entry queue of classified chunks between the front and the back.
// ----------------------------------------------------------------------------
module fcr_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    output logic          q_full,
    input  fcr_pkg::cls_t wr_data,
    input  logic          rd_en,
    output logic          q_empty,
    output fcr_pkg::cls_t rd_data
);

    fcr_pkg::cls_t mem [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          do_wr;
    logic          do_rd;

    assign q_full  = count_reg == 2'd2;
    assign q_empty = count_reg == 2'd0;
    assign do_wr   = wr_en & ~q_full;
    assign do_rd   = rd_en & ~q_empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 2'd1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- hdl/fcr_back.sv -----
// ----------------------------------------------------------------------------
// fcr_back
// Frame tracker: applies one classified chunk per cycle, while the result queue
// has room, to the reassembly state and queues the result for the consumer.
// ----------------------------------------------------------------------------
module fcr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    output logic             q_pop,
    input  fcr_pkg::cls_t    cls,
    output logic             empty,
    input  logic             pop,
    output fcr_pkg::result_t result
);

    logic                                 assembling_reg;
    logic [63:0]                          current_frame_reg;
    logic [63:0]                          current_stamp_reg;
    logic [fcr_pkg::FRAME_BYTES_W-1:0]    expected_bytes_reg;
    logic [fcr_pkg::FRAME_BYTES_W-1:0]    received_bytes_reg;
    logic [fcr_pkg::CHUNK_CNT_W-1:0]      expected_chunks_reg;
    logic [fcr_pkg::CHUNK_CNT_W-1:0]      next_index_reg;
    logic [7:0]                           current_kind_reg;

    logic                                 assembling_next;
    logic [63:0]                          current_frame_next;
    logic [63:0]                          current_stamp_next;
    logic [fcr_pkg::FRAME_BYTES_W-1:0]    expected_bytes_next;
    logic [fcr_pkg::FRAME_BYTES_W-1:0]    received_bytes_next;
    logic [fcr_pkg::CHUNK_CNT_W-1:0]      expected_chunks_next;
    logic [fcr_pkg::CHUNK_CNT_W-1:0]      next_index_next;
    logic [7:0]                           current_kind_next;

    fcr_pkg::result_t                     res;
    logic                                 new_frame;
    logic [fcr_pkg::FRAME_BYTES_W-1:0]    byte_sum;
    logic [fcr_pkg::CHUNK_CNT_W-1:0]      idx_inc;

    // result queue
    fcr_pkg::result_t                     res_mem [2];
    logic                                 res_wr_ptr_reg;
    logic                                 res_rd_ptr_reg;
    logic [1:0]                           res_count_reg;
    logic                                 res_wr;
    logic                                 res_rd;

    assign q_pop  = ~q_empty & (res_count_reg != 2'd2);
    assign res_wr = q_pop;
    assign res_rd = pop & ~empty;
    assign empty  = res_count_reg == 2'd0;
    assign result = res_mem[res_rd_ptr_reg];

    always_comb
    begin
        assembling_next      = assembling_reg;
        current_frame_next   = current_frame_reg;
        current_stamp_next   = current_stamp_reg;
        expected_bytes_next  = expected_bytes_reg;
        received_bytes_next  = received_bytes_reg;
        expected_chunks_next = expected_chunks_reg;
        next_index_next      = next_index_reg;
        current_kind_next    = current_kind_reg;
        res                  = '0;
        res.verdict          = fcr_pkg::VERDICT_ACCEPTED;
        new_frame            = ~assembling_reg | (current_frame_reg != cls.frame_id);
        byte_sum             = '0;
        idx_inc              = '0;

        if (cls.malformed)
        begin
            res.verdict = fcr_pkg::VERDICT_MALFORMED;
        end
        else if (new_frame && cls.index != '0)
        begin
            res.prior_frame_dropped = assembling_reg;
            res.verdict             = fcr_pkg::VERDICT_STRAY_START;
            assembling_next         = 1'b0;
            received_bytes_next     = '0;
            next_index_next         = '0;
            expected_bytes_next     = '0;
            expected_chunks_next    = '0;
        end
        else if (!new_frame && (expected_bytes_reg != cls.frame_bytes ||
                 expected_chunks_reg != cls.count || next_index_reg != cls.index))
        begin
            res.verdict          = fcr_pkg::VERDICT_MISMATCH;
            assembling_next      = 1'b0;
            received_bytes_next  = '0;
            next_index_next      = '0;
            expected_bytes_next  = '0;
            expected_chunks_next = '0;
        end
        else
        begin
            // a new frame starts from zero received bytes and index zero
            res.prior_frame_dropped = new_frame & assembling_reg;
            if (new_frame)
            begin
                current_frame_next   = cls.frame_id;
                current_stamp_next   = cls.time_stamp;
                current_kind_next    = cls.kind;
                expected_bytes_next  = cls.frame_bytes;
                expected_chunks_next = cls.count;
                byte_sum = fcr_pkg::FRAME_BYTES_W'(cls.length);
                idx_inc  = fcr_pkg::CHUNK_CNT_W'(1);
            end
            else
            begin
                // at most 64 chunks of 8192 bytes, so the sum fits
                byte_sum = received_bytes_reg + fcr_pkg::FRAME_BYTES_W'(cls.length);
                idx_inc  = next_index_reg + fcr_pkg::CHUNK_CNT_W'(1);
            end
            assembling_next     = 1'b1;
            received_bytes_next = byte_sum;
            next_index_next     = idx_inc;
            res.write_offset    = cls.offset;
            res.write_length    = cls.length;
            if (received_bytes_next == expected_bytes_next &&
                idx_inc == expected_chunks_next)
            begin
                assembling_next      = 1'b0;
                res.frame_complete   = 1'b1;
                res.done_frame_id    = current_frame_next;
                res.done_time_stamp  = current_stamp_next;
                res.done_frame_kind  = current_kind_next;
                res.done_frame_bytes = received_bytes_next;
                res.done_chunk_total = expected_chunks_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            assembling_reg      <= 1'b0;
            current_frame_reg   <= '0;
            current_stamp_reg   <= '0;
            expected_bytes_reg  <= '0;
            received_bytes_reg  <= '0;
            expected_chunks_reg <= '0;
            next_index_reg      <= '0;
            current_kind_reg    <= '0;
            res_wr_ptr_reg      <= 1'b0;
            res_rd_ptr_reg      <= 1'b0;
            res_count_reg       <= 2'd0;
        end
        else
        begin
            if (q_pop)
            begin
                assembling_reg      <= assembling_next;
                current_frame_reg   <= current_frame_next;
                current_stamp_reg   <= current_stamp_next;
                expected_bytes_reg  <= expected_bytes_next;
                received_bytes_reg  <= received_bytes_next;
                expected_chunks_reg <= expected_chunks_next;
                next_index_reg      <= next_index_next;
                current_kind_reg    <= current_kind_next;
            end
            if (res_wr)
                res_wr_ptr_reg <= ~res_wr_ptr_reg;
            if (res_rd)
                res_rd_ptr_reg <= ~res_rd_ptr_reg;
            if (res_wr && !res_rd)
                res_count_reg <= res_count_reg + 2'd1;
            else if (res_rd && !res_wr)
                res_count_reg <= res_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_wr)
            res_mem[res_wr_ptr_reg] <= res;
    end

endmodule

// ----- hdl/frame_chunk_reassembly_checker.sv -----
// A request is registered in the front stage, the command queue and the result
// queue in turn. Throughput: one request per cycle while results are popped;
// the frame tracker applies one chunk per cycle; two-entry queues flank it.
// Reset (rst_n low, asynchronous): queues empty, no frame in progress,
// stream id check off and expected stream id zero.
// ----------------------------------------------------------------------------
// frame_chunk_reassembly_checker
// Validates chunk headers and tracks reassembly of one frame at a time.
// ----------------------------------------------------------------------------
module frame_chunk_reassembly_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [fcr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fcr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            push,
    output logic                            full,
    input  fcr_pkg::chunk_t                 chunk,
    output logic                            empty,
    input  logic                            pop,
    output fcr_pkg::result_t                result
);

    logic          cls_valid;
    logic          cls_full;
    fcr_pkg::cls_t cls_in;
    fcr_pkg::cls_t cls_out;
    logic          q_empty;
    logic          q_pop;

    fcr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .chunk     (chunk),
        .cls_valid (cls_valid),
        .cls_full  (cls_full),
        .cls       (cls_in)
    );

    fcr_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cls_valid),
        .q_full  (cls_full),
        .wr_data (cls_in),
        .rd_en   (q_pop),
        .q_empty (q_empty),
        .rd_data (cls_out)
    );

    fcr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .cls     (cls_out),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
